// ----- hw/rtl/stl_pkg.sv -----
// Shared types, constants and keyword tables for the script token lexer.
`timescale 1ns / 1ps
package stl_pkg;

   localparam int KwCount = 18;
   localparam logic [23:0] PosMax = 24'hFFFFFF;

   localparam logic [1:0] RecText = 2'd0;
   localparam logic [1:0] RecEnd  = 2'd1;
   localparam logic [1:0] RecEos  = 2'd2;

   localparam logic [2:0] TokIdent   = 3'd0;
   localparam logic [2:0] TokKeyword = 3'd1;
   localparam logic [2:0] TokNumber  = 3'd2;
   localparam logic [2:0] TokString  = 3'd3;
   localparam logic [2:0] TokSymbol  = 3'd4;

   typedef enum logic [6:0] {
      MODE_IDLE    = 7'b0000001,
      MODE_IDENT   = 7'b0000010,
      MODE_NUMBER  = 7'b0000100,
      MODE_STRING  = 7'b0001000,
      MODE_ESCAPE  = 7'b0010000,
      MODE_HELD    = 7'b0100000,
      MODE_COMMENT = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [7:0]  text_byte;
      logic [2:0]  token_type;
      logic [4:0]  keyword_index;
      logic [23:0] start_line;
      logic [23:0] start_column;
      logic [6:0]  text_length;
      logic        truncated;
      logic        last;
   } record_type;

   function automatic logic [3:0] kw_len(input int i);
      logic [3:0] r;
      case (i)
         0: r = 4'd3;  1: r = 4'd5;  2: r = 4'd2;  3: r = 4'd6;
         4: r = 4'd2;  5: r = 4'd4;  6: r = 4'd4;  7: r = 4'd3;
         8: r = 4'd2;  9: r = 4'd5;  10: r = 4'd5; 11: r = 4'd8;
         12: r = 4'd4; 13: r = 4'd5; 14: r = 4'd4; 15: r = 4'd3;
         16: r = 4'd2; default: r = 4'd3;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] kw_word(input int i);
      logic [63:0] r;
      case (i)
         0: r = "let";     1: r = "const";    2: r = "fn";     3: r = "return";
         4: r = "if";      5: r = "else";     6: r = "elif";   7: r = "for";
         8: r = "in";      9: r = "while";    10: r = "break"; 11: r = "continue";
         12: r = "true";   13: r = "false";   14: r = "none";  15: r = "and";
         16: r = "or";     default: r = "not";
      endcase
      return r;
   endfunction

   // character at position pos of keyword i (first char at pos 0)
   function automatic logic [7:0] kw_char(input int i, input logic [2:0] pos);
      logic [63:0] w;
      logic [3:0]  sh;
      w  = kw_word(i);
      sh = kw_len(i) - 4'd1 - {1'b0, pos};
      return w[{sh[2:0], 3'b000} +: 8];
   endfunction

endpackage

// ----- hw/rtl/stl_if.sv -----
// Valid/ready channel interfaces for source bytes and token records.
`timescale 1ns / 1ps
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] ch;
   modport source (output valid, kind, ch, input ready);
   modport sink (input valid, kind, ch, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [7:0]  text_byte;
   logic [2:0]  token_type;
   logic [4:0]  keyword_index;
   logic [23:0] start_line;
   logic [23:0] start_column;
   logic [6:0]  text_length;
   logic        truncated;
   logic        last;
   modport source (output valid, record_kind, text_byte, token_type, keyword_index,
                   start_line, start_column, text_length, truncated, last,
                   input ready);
   modport sink (input valid, record_kind, text_byte, token_type, keyword_index,
                 start_line, start_column, text_length, truncated, last,
                 output ready);
endinterface

// ----- hw/rtl/script_token_lexer_top.sv -----
// Streaming tokenizer: source bytes in, token text and end records out.
`timescale 1ns / 1ps
// Usage:
//   req_bus carries one source byte per beat (kind 0) or end of source
//   (kind 1). rsp_bus carries records: token text bytes, token end records
//   and one end-of-source record; last marks the final record of a beat.
//   A request beat is decoded in the cycle it is accepted and its records
//   (up to four) are written into an eight-entry record queue; the first
//   record is offered on rsp_bus the next cycle if the queue was empty, one
//   record per cycle while rsp_bus.ready is high. req_bus.ready is high while
//   the queue holds four records or fewer, so a new byte is taken every cycle
//   while that holds; the sustained rate is set by the one-record-per-cycle
//   queue read port.
//   Reset empties the queue and returns the scanner to idle at line 1,
//   column 1. A stall on rsp_bus holds the head record; once the queue
//   fills past four records, request beats wait.
module script_token_lexer_top import stl_pkg::*; #(
   parameter int TEXT_CAP = 127
) (
   input logic clock,
   input logic reset,
   stl_req_if.sink   req_bus,
   stl_rsp_if.source rsp_bus
);

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  held;
      logic [23:0] line;
      logic [23:0] col;
      logic [23:0] sl;
      logic [23:0] sc;
      logic [7:0]  cnt;
      logic [KwCount-1:0] kwc;
      logic        ovf;
   } lex_state_type;

   typedef struct packed {
      record_type [3:0] rec;
      logic [2:0]       k;
   } rec_buf_type;

   lex_state_type st_ff, st_in;
   record_type    q_ff [8];
   logic [2:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [3:0]    cnt_ff, cnt_in;
   rec_buf_type   bo;
   logic          push, pop;

   function automatic void put_rec(inout rec_buf_type b, input record_type r);
      b.rec[b.k[1:0]] = r;
      b.k = b.k + 3'd1;
   endfunction

   function automatic void col_step(inout lex_state_type s);
      if (s.col < PosMax) s.col = s.col + 24'd1;
   endfunction

   function automatic void mark_start(inout lex_state_type s);
      s.sl  = s.line;
      s.sc  = s.col;
      s.cnt = '0;
      s.ovf = 1'b0;
      s.kwc = '1;
   endfunction

   function automatic void add_text(inout lex_state_type s, inout rec_buf_type b,
                                    input logic [7:0] c);
      record_type r;
      r = '0;
      if ({24'd0, s.cnt} < TEXT_CAP) begin
         r.record_kind = RecText;
         r.text_byte   = c;
         put_rec(b, r);
         s.cnt = s.cnt + 8'd1;
      end else begin
         s.ovf = 1'b1;
      end
   endfunction

   function automatic void narrow(inout lex_state_type s, input logic [7:0] c);
      for (int i = 0; i < KwCount; i++) begin
         if (s.cnt >= {4'd0, kw_len(i)} || kw_char(i, s.cnt[2:0]) != c) s.kwc[i] = 1'b0;
      end
   endfunction

   function automatic void end_token(inout lex_state_type s, inout rec_buf_type b,
                                     input logic [2:0] t);
      record_type r;
      logic [2:0] ty;
      logic [4:0] kwi;
      ty  = t;
      kwi = '0;
      if (t == TokIdent && !s.ovf) begin
         for (int i = 0; i < KwCount; i++) begin
            if (s.kwc[i] && {4'd0, kw_len(i)} == s.cnt) begin
               ty  = TokKeyword;
               kwi = 5'(i);
            end
         end
      end
      s.mode = MODE_IDLE;
      r = '0;
      r.record_kind   = RecEnd;
      r.token_type    = ty;
      r.keyword_index = kwi;
      r.start_line    = s.sl;
      r.start_column  = s.sc;
      r.text_length   = s.cnt[6:0];
      r.truncated     = s.ovf;
      put_rec(b, r);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void from_idle(inout lex_state_type s, inout rec_buf_type b,
                                     input logic [7:0] c);
      s.mode = MODE_IDLE;
      if (c == 8'h0A) begin
         if (s.line < PosMax) s.line = s.line + 24'd1;
         s.col = 24'd1;
      end else if (c == " " || c == 8'h09 || c == 8'h0D) begin
         col_step(s);
      end else if (c == "#") begin
         s.mode = MODE_COMMENT;
      end else if (is_alpha(c)) begin
         mark_start(s);
         narrow(s, c);
         add_text(s, b, c);
         col_step(s);
         s.mode = MODE_IDENT;
      end else if (is_digit(c)) begin
         mark_start(s);
         add_text(s, b, c);
         col_step(s);
         s.mode = MODE_NUMBER;
      end else if (c == 8'h22) begin
         mark_start(s);
         col_step(s);
         s.mode = MODE_STRING;
      end else if (c == "=" || c == "!" || c == "<" || c == ">" ||
                   c == "&" || c == "|" || c == "/") begin
         mark_start(s);
         s.held = c;
         col_step(s);
         s.mode = MODE_HELD;
      end else begin
         mark_start(s);
         add_text(s, b, c);
         col_step(s);
         end_token(s, b, TokSymbol);
      end
   endfunction

   always_comb begin
      lex_state_type s;
      rec_buf_type   b;
      record_type    r;
      logic [7:0]    c, h;
      s = st_ff;
      b = '0;
      r = '0;
      c = req_bus.ch;
      h = st_ff.held;
      if (req_bus.kind) begin
         unique case (st_ff.mode)
            MODE_IDENT:  end_token(s, b, TokIdent);
            MODE_NUMBER: end_token(s, b, TokNumber);
            MODE_ESCAPE: begin
               add_text(s, b, 8'h5C);
               end_token(s, b, TokString);
            end
            MODE_STRING: end_token(s, b, TokString);
            MODE_HELD: begin
               add_text(s, b, h);
               end_token(s, b, TokSymbol);
            end
            default: ;
         endcase
         r.record_kind = RecEos;
         put_rec(b, r);
         s.mode = MODE_IDLE;
         s.held = '0;
         s.line = 24'd1;
         s.col  = 24'd1;
      end else begin
         unique case (st_ff.mode)
            MODE_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  narrow(s, c);
                  add_text(s, b, c);
                  col_step(s);
               end else begin
                  end_token(s, b, TokIdent);
                  from_idle(s, b, c);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(c) || c == ".") begin
                  add_text(s, b, c);
                  col_step(s);
               end else begin
                  end_token(s, b, TokNumber);
                  from_idle(s, b, c);
               end
            end
            MODE_STRING: begin
               col_step(s);
               if (c == 8'h22) end_token(s, b, TokString);
               else if (c == 8'h5C) s.mode = MODE_ESCAPE;
               else add_text(s, b, c);
            end
            MODE_ESCAPE: begin
               col_step(s);
               if (c == "n") c = 8'h0A;
               else if (c == "t") c = 8'h09;
               add_text(s, b, c);
               s.mode = MODE_STRING;
            end
            MODE_HELD: begin
               if ((c == "=" && (h == "=" || h == "!" || h == "<" || h == ">")) ||
                   ((h == "&" || h == "|") && c == h)) begin
                  add_text(s, b, h);
                  add_text(s, b, c);
                  col_step(s);
                  end_token(s, b, TokSymbol);
               end else if (h == "/" && c == "/") begin
                  s.mode = MODE_COMMENT;
               end else begin
                  add_text(s, b, h);
                  end_token(s, b, TokSymbol);
                  from_idle(s, b, c);
               end
               s.held = '0;
            end
            MODE_COMMENT: begin
               if (c == 8'h0A) from_idle(s, b, c);
            end
            default: from_idle(s, b, c);
         endcase
      end
      for (int j = 0; j < 4; j++) b.rec[j].last = (3'(j) == b.k - 3'd1);
      st_in = s;
      bo    = b;
   end

   assign req_bus.ready = (cnt_ff <= 4'd4);
   assign push = req_bus.valid && req_bus.ready;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_in  = push ? wr_ff + bo.k : wr_ff;
      rd_in  = pop ? rd_ff + 3'd1 : rd_ff;
      cnt_in = cnt_ff + (push ? {1'b0, bo.k} : 4'd0) - (pop ? 4'd1 : 4'd0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int j = 0; j < 4; j++) begin
            if (3'(j) < bo.k) q_ff[wr_ff + 3'(j)] <= bo.rec[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode <= MODE_IDLE;
         st_ff.held <= '0;
         st_ff.line <= 24'd1;
         st_ff.col  <= 24'd1;
         st_ff.sl   <= 24'd1;
         st_ff.sc   <= 24'd1;
         st_ff.cnt  <= '0;
         st_ff.kwc  <= '1;
         st_ff.ovf  <= 1'b0;
         wr_ff      <= '0;
         rd_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         if (push) st_ff <= st_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_bus.valid         = (cnt_ff != 4'd0);
   assign rsp_bus.record_kind   = q_ff[rd_ff].record_kind;
   assign rsp_bus.text_byte     = q_ff[rd_ff].text_byte;
   assign rsp_bus.token_type    = q_ff[rd_ff].token_type;
   assign rsp_bus.keyword_index = q_ff[rd_ff].keyword_index;
   assign rsp_bus.start_line    = q_ff[rd_ff].start_line;
   assign rsp_bus.start_column  = q_ff[rd_ff].start_column;
   assign rsp_bus.text_length   = q_ff[rd_ff].text_length;
   assign rsp_bus.truncated     = q_ff[rd_ff].truncated;
   assign rsp_bus.last          = q_ff[rd_ff].last;

endmodule

// ----- test/tb_script_token_lexer_top.sv -----
// Self-checking testbench for the script token lexer: directed and random source text.
`timescale 1ns / 1ps
module tb_script_token_lexer_top;
   import stl_pkg::*;

   localparam int TextCap = 127;

   // Scanner modes of the predictor
   typedef enum int {
      SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_ESCAPE, SCAN_HELD, SCAN_COMMENT
   } scan_state_type;

   logic clock;
   logic reset;

   stl_req_if req_bus ();
   stl_rsp_if rsp_bus ();

   script_token_lexer_top #(.TEXT_CAP(TextCap)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Predictor state
   scan_state_type scan;
   logic [7:0]  held;
   logic [23:0] line_no, col_no, tok_line, tok_col;
   int          tok_len;
   logic [17:0] kw_live;
   logic        over_cap;

   record_type  pending_records[$];
   record_type  beat_records[$];
   int          errors = 0;
   int          records_seen = 0;
   int          tokens_seen = 0;
   int          bytes_sent = 0;
   bit          rsp_stall_enable = 1'b1;

   function automatic string kw_string(int i);
      string s;
      case (i)
         0: s = "let";    1: s = "const"; 2: s = "fn";     3: s = "return";
         4: s = "if";     5: s = "else";  6: s = "elif";   7: s = "for";
         8: s = "in";     9: s = "while"; 10: s = "break"; 11: s = "continue";
         12: s = "true";  13: s = "false"; 14: s = "none"; 15: s = "and";
         16: s = "or";    default: s = "not";
      endcase
      return s;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_lookahead(logic [7:0] c);
      return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" || c == "/";
   endfunction

   task automatic push_record(logic [1:0] rk, logic [7:0] b, logic [2:0] tt, logic [4:0] kwi,
                              logic [23:0] sl, logic [23:0] sc, logic [6:0] len, logic tr);
      record_type r;
      r = '0;
      r.record_kind = rk; r.text_byte = b; r.token_type = tt; r.keyword_index = kwi;
      r.start_line = sl; r.start_column = sc; r.text_length = len; r.truncated = tr;
      beat_records.push_back(r);
   endtask

   task automatic bump_column();
      if (col_no != PosMax) col_no++;
   endtask

   task automatic open_token();
      tok_line = line_no; tok_col = col_no; tok_len = 0; over_cap = 1'b0; kw_live = '1;
   endtask

   task automatic append_text(logic [7:0] c);
      if (tok_len < TextCap) begin
         push_record(RecText, c, '0, '0, '0, '0, '0, 1'b0);
         tok_len++;
      end else begin
         over_cap = 1'b1;
      end
   endtask

   task automatic filter_keywords(int pos, logic [7:0] c);
      string w;
      for (int i = 0; i < KwCount; i++) begin
         w = kw_string(i);
         if (pos >= w.len() || w[pos] != c) kw_live[i] = 1'b0;
      end
   endtask

   task automatic close_token(logic [2:0] tt);
      logic [4:0] kwi;
      string      w;
      kwi = '0;
      if (tt == TokIdent && !over_cap)
         for (int i = 0; i < KwCount; i++) begin
            w = kw_string(i);
            if (kw_live[i] && w.len() == tok_len) begin
               tt = TokKeyword; kwi = i[4:0];
            end
         end
      scan = SCAN_IDLE;
      push_record(RecEnd, '0, tt, kwi, tok_line, tok_col, tok_len[6:0], over_cap);
   endtask

   task automatic scan_from_idle(logic [7:0] c);
      scan = SCAN_IDLE;
      if (c == 8'h0a) begin
         if (line_no != PosMax) line_no++;
         col_no = 1;
      end else if (c == " " || c == 8'h09 || c == 8'h0d) begin
         bump_column();
      end else if (c == "#") begin
         scan = SCAN_COMMENT;
      end else if (is_letter(c)) begin
         open_token(); filter_keywords(0, c); append_text(c); bump_column();
         scan = SCAN_IDENT;
      end else if (is_digit(c)) begin
         open_token(); append_text(c); bump_column();
         scan = SCAN_NUMBER;
      end else if (c == "\"") begin
         open_token(); bump_column();
         scan = SCAN_STRING;
      end else if (is_lookahead(c)) begin
         open_token(); held = c; bump_column();
         scan = SCAN_HELD;
      end else begin
         open_token(); append_text(c); bump_column();
         close_token(TokSymbol);
      end
   endtask

   task automatic lexer_reset();
      scan = SCAN_IDLE; held = '0; line_no = 1; col_no = 1; tok_line = 1; tok_col = 1;
      tok_len = 0; kw_live = '1; over_cap = 1'b0;
   endtask

   // Work out the records that one source beat causes and queue them.
   task automatic predict_tokens(logic kind, logic [7:0] c);
      logic [7:0] h;
      record_type r;
      h = held;
      beat_records.delete();
      if (kind) begin
         case (scan)
            SCAN_IDENT:  close_token(TokIdent);
            SCAN_NUMBER: close_token(TokNumber);
            SCAN_ESCAPE: begin append_text("\\"); close_token(TokString); end
            SCAN_STRING: close_token(TokString);
            SCAN_HELD:   begin append_text(h); close_token(TokSymbol); end
            default: ;
         endcase
         push_record(RecEos, '0, '0, '0, '0, '0, '0, 1'b0);
         scan = SCAN_IDLE; held = '0; line_no = 1; col_no = 1;
      end else begin
         case (scan)
            SCAN_IDENT: begin
               if (is_letter(c) || is_digit(c)) begin
                  filter_keywords(tok_len, c); append_text(c); bump_column();
               end else begin
                  close_token(TokIdent); scan_from_idle(c);
               end
            end
            SCAN_NUMBER: begin
               if (is_digit(c) || c == ".") begin
                  append_text(c); bump_column();
               end else begin
                  close_token(TokNumber); scan_from_idle(c);
               end
            end
            SCAN_STRING: begin
               bump_column();
               if (c == "\"") close_token(TokString);
               else if (c == "\\") scan = SCAN_ESCAPE;
               else append_text(c);
            end
            SCAN_ESCAPE: begin
               bump_column();
               if (c == "n") c = 8'h0a;
               else if (c == "t") c = 8'h09;
               append_text(c);
               scan = SCAN_STRING;
            end
            SCAN_HELD: begin
               if ((c == "=" && (h == "=" || h == "!" || h == "<" || h == ">")) ||
                   ((h == "&" || h == "|") && c == h)) begin
                  append_text(h); append_text(c); bump_column(); close_token(TokSymbol);
               end else if (h == "/" && c == "/") begin
                  scan = SCAN_COMMENT;
               end else begin
                  append_text(h); close_token(TokSymbol); scan_from_idle(c);
               end
               held = '0;
            end
            SCAN_COMMENT: if (c == 8'h0a) scan_from_idle(c);
            default: scan_from_idle(c);
         endcase
      end
      if (beat_records.size() > 0) beat_records[beat_records.size() - 1].last = 1'b1;
      foreach (beat_records[i]) begin
         r = beat_records[i];
         pending_records.push_back(r);
      end
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2);
      repeat (n) @(posedge clock);
   endtask

   bit sender_gaps = 1'b1;

   // Send one beat; the prediction is made when the beat is accepted.
   // Valid stays high after the beat so the next beat can follow at once.
   task automatic send_beat(logic kind, logic [7:0] c);
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         idle_gap();
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.ch    <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_tokens(kind, c);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_records.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, compare each record with the oldest expectation.
   always @(posedge clock) begin
      record_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.record_kind = rsp_bus.record_kind; got.text_byte = rsp_bus.text_byte;
         got.token_type = rsp_bus.token_type; got.keyword_index = rsp_bus.keyword_index;
         got.start_line = rsp_bus.start_line; got.start_column = rsp_bus.start_column;
         got.text_length = rsp_bus.text_length; got.truncated = rsp_bus.truncated;
         got.last = rsp_bus.last;
         records_seen++;
         if (got.record_kind == RecEnd) tokens_seen++;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record, expected none actual %p", $time, got);
            errors++;
         end else begin
            want = pending_records.pop_front();
            if (got !== want) begin
               $display("%0t: record mismatch expected %p actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall_enable && $urandom_range(0, 4) == 0) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic test_keywords();
      send_text("let continue while elif not lets _x9 Zq ");
      send_beat(1'b1, 8'h00);
   endtask

   task automatic test_numbers_and_strings();
      send_text("3.14.1 0\"a\\n\\t\\\\\\\"b\nc\" 9");
      send_text("\"end\\");
      send_beat(1'b1, 8'h00);
      send_text("\"open");
      send_beat(1'b1, 8'h00);
   endtask

   task automatic test_symbols_and_comments();
      send_text("== <= && || = <x /x a//c\n#h\n+");
      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hff);
      send_beat(1'b0, "<");
      send_beat(1'b1, 8'h00);
      send_beat(1'b1, 8'h00);
   endtask

   task automatic test_text_cap();
      send_beat(1'b0, "k");
      for (int i = 0; i < 128; i++) send_beat(1'b0, 8'("a" + (i % 26)));
      send_beat(1'b0, " ");
      send_beat(1'b1, 8'h00);
   endtask

   task automatic test_drained_pause();
      send_text("x=1");
      wait_drained();
      send_text("y");
      send_beat(1'b1, 8'h00);
   endtask

   // Random source text: mostly well-formed tokens with random content, some noise.
   task automatic test_random_text();
      int pick;
      string frag;
      for (int n = 0; n < 16; ) begin
         pick = $urandom_range(0, 11);
         case (pick)
            0: frag = kw_string($urandom_range(0, KwCount - 1));
            1: frag = $sformatf("v%c", 8'("a" + $urandom_range(0, 25)));
            2: frag = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 9));
            3: frag = "\"s\\nq\"";
            4: frag = "==";
            5: frag = "&&";
            6: frag = "// note\n";
            7: frag = "#x\n";
            8: frag = "\n";
            9: frag = "\t";
            default: frag = "";
         endcase
         if (pick >= 10) begin
            send_beat(1'b0, 8'($urandom_range(0, 255)));
            n++;
         end else begin
            send_text(frag);
            n += frag.len();
         end
         send_beat(1'b0, " ");
         n++;
         if ($urandom_range(0, 40) == 0) send_beat(1'b1, 8'h00);
      end
      send_beat(1'b1, 8'h00);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = 1'b0;
      req_bus.ch = '0;
      lexer_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_keywords();
      test_numbers_and_strings();
      test_symbols_and_comments();
      test_drained_pause();
      sender_gaps = 1'b0;
      rsp_stall_enable = 1'b0;
      test_text_cap();
      sender_gaps = 1'b1;
      rsp_stall_enable = 1'b1;
      test_random_text();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d source beats, checked %0d records and %0d tokens", bytes_sent,
               records_seen, tokens_seen);
      $display("Covered keywords, numbers, escaped strings, paired symbols, comments, cap");
      if (errors == 0 && pending_records.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d records outstanding", pending_records.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/stl_pkg.sv
hw/rtl/stl_if.sv
hw/rtl/script_token_lexer_top.sv
test/tb_script_token_lexer_top.sv
